FILE: rtl/vspc_pkg.sv
// ============================================================================
// vspc_pkg
// Shared types and constants of the composite video sync pulse classifier.
// ============================================================================
package vspc_pkg;

    // Sync tracking states.
    localparam logic [2:0] ST_WAIT  = 3'd0;
    localparam logic [2:0] ST_PRE   = 3'd1;
    localparam logic [2:0] ST_SYNC  = 3'd2;
    localparam logic [2:0] ST_POST  = 3'd3;
    localparam logic [2:0] ST_HSYNC = 3'd4;

    // Video standard codes.
    localparam logic [1:0] STD_UNKNOWN = 2'd0;
    localparam logic [1:0] STD_PAL     = 2'd1;
    localparam logic [1:0] STD_NTSC    = 2'd2;

    // Broad pulse counts that identify the standard.
    localparam logic [7:0] PAL_BROAD  = 8'd5;
    localparam logic [7:0] NTSC_BROAD = 8'd6;

    // First visible line of the second field; the first field starts one earlier.
    localparam logic [9:0] WINDOW_START = 10'd15;

    // Configuration register indexes.
    localparam int unsigned REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_VSYNC_MIN = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_VSYNC_MAX = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_HSYNC_MIN = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SHORT_MAX = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_HSYNC_MAX = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BROAD_MIN = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_BROAD_MAX = 3'd6;

    // Threshold set seen by the classifier.
    typedef struct packed {
        logic [15:0] vsync_min;
        logic [15:0] vsync_max;
        logic [15:0] hsync_min;
        logic [15:0] short_max;
        logic [15:0] hsync_max;
        logic [15:0] broad_min;
        logic [15:0] broad_max;
    } t_cfg;

    // One result transaction.
    typedef struct packed {
        logic [2:0]  sync_state;
        logic        second_field;
        logic [1:0]  video_mode;
        logic [9:0]  field_line;
        logic [15:0] frame_line;
        logic [9:0]  visible_line;
        logic        start_pixels;
        logic        fill_request;
        logic        fill_buffer;
        logic        frame_start;
        logic        pulse_error;
        logic [15:0] error_total;
    } t_result;

endpackage

FILE: rtl/vspc_if.sv
// ============================================================================
// vspc_if
// Valid/ready channels for comparator edges and for classifier results.
// ============================================================================
interface vspc_edge_if;
    logic        valid;
    logic        ready;
    logic [15:0] capture_time;
    logic        falling_edge;

    modport source (output valid, capture_time, falling_edge, input ready);
    modport sink   (input valid, capture_time, falling_edge, output ready);
    modport monitor (input valid, ready, capture_time, falling_edge);
endinterface

interface vspc_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  sync_state;
    logic        second_field;
    logic [1:0]  video_mode;
    logic [9:0]  field_line;
    logic [15:0] frame_line;
    logic [9:0]  visible_line;
    logic        start_pixels;
    logic        fill_request;
    logic        fill_buffer;
    logic        frame_start;
    logic        pulse_error;
    logic [15:0] error_total;

    modport source (
        output valid, sync_state, second_field, video_mode, field_line, frame_line,
               visible_line, start_pixels, fill_request, fill_buffer, frame_start,
               pulse_error, error_total,
        input  ready
    );
    modport sink (
        input  valid, sync_state, second_field, video_mode, field_line, frame_line,
               visible_line, start_pixels, fill_request, fill_buffer, frame_start,
               pulse_error, error_total,
        output ready
    );
    modport monitor (
        input valid, ready, sync_state, second_field, video_mode, field_line, frame_line,
              visible_line, start_pixels, fill_request, fill_buffer, frame_start,
              pulse_error, error_total
    );
endinterface

FILE: rtl/vspc_apb_regs.sv
// ============================================================================
// vspc_apb_regs
// APB register file holding the pulse length thresholds.
// ============================================================================
module vspc_apb_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output vspc_pkg::t_cfg     o_cfg
);

    vspc_pkg::t_cfg r_cfg;
    logic [vspc_pkg::REG_IDX_W-1:0] reg_idx;
    logic wr_en;
    logic [15:0] rd_val;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel & penable & pwrite & pready;

    // Register writes in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vsync_min <= 16'd1280;
            r_cfg.vsync_max <= 16'd2292;
            r_cfg.hsync_min <= 16'd320;
            r_cfg.short_max <= 16'd280;
            r_cfg.hsync_max <= 16'd480;
            r_cfg.broad_min <= 16'd2000;
            r_cfg.broad_max <= 16'd2320;
        end else if (wr_en) begin
            case (reg_idx)
                vspc_pkg::REG_VSYNC_MIN: r_cfg.vsync_min <= pwdata[15:0];
                vspc_pkg::REG_VSYNC_MAX: r_cfg.vsync_max <= pwdata[15:0];
                vspc_pkg::REG_HSYNC_MIN: r_cfg.hsync_min <= pwdata[15:0];
                vspc_pkg::REG_SHORT_MAX: r_cfg.short_max <= pwdata[15:0];
                vspc_pkg::REG_HSYNC_MAX: r_cfg.hsync_max <= pwdata[15:0];
                vspc_pkg::REG_BROAD_MIN: r_cfg.broad_min <= pwdata[15:0];
                vspc_pkg::REG_BROAD_MAX: r_cfg.broad_max <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read-back mux; unmapped addresses read as zero.
    always_comb begin
        case (reg_idx)
            vspc_pkg::REG_VSYNC_MIN: rd_val = r_cfg.vsync_min;
            vspc_pkg::REG_VSYNC_MAX: rd_val = r_cfg.vsync_max;
            vspc_pkg::REG_HSYNC_MIN: rd_val = r_cfg.hsync_min;
            vspc_pkg::REG_SHORT_MAX: rd_val = r_cfg.short_max;
            vspc_pkg::REG_HSYNC_MAX: rd_val = r_cfg.hsync_max;
            vspc_pkg::REG_BROAD_MIN: rd_val = r_cfg.broad_min;
            vspc_pkg::REG_BROAD_MAX: rd_val = r_cfg.broad_max;
            default:                 rd_val = 16'd0;
        endcase
    end

    assign prdata = {16'd0, rd_val};
    assign o_cfg  = r_cfg;

endmodule

FILE: rtl/vspc_classifier.sv
// ============================================================================
// vspc_classifier
// Pulse classification and sync state tracking for one edge per cycle.
// ============================================================================
module vspc_classifier #(
    parameter int PAL_LINES_SHOWN  = 288,
    parameter int NTSC_LINES_SHOWN = 240
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  vspc_pkg::t_cfg      i_cfg,
    input  logic [15:0]         i_capture_time,
    input  logic                i_falling_edge,
    output vspc_pkg::t_result   o_result
);

    localparam logic [9:0] PAL_SPAN  = 10'(PAL_LINES_SHOWN - 1);
    localparam logic [9:0] NTSC_SPAN = 10'(NTSC_LINES_SHOWN - 1);

    logic [15:0] r_prev_capture, n_prev_capture;
    logic [15:0] r_prev_length,  n_prev_length;
    logic [2:0]  r_status,       n_status;
    logic        r_second,       n_second;
    logic [1:0]  r_mode,         n_mode;
    logic [7:0]  r_broad_count,  n_broad_count;
    logic [9:0]  r_line,         n_line;
    logic [15:0] r_line_total,   n_line_total;
    logic [9:0]  r_vis_index,    n_vis_index;
    logic        r_next_vis,     n_next_vis;
    logic [9:0]  r_first_vis,    n_first_vis;
    logic [9:0]  r_last_vis,     n_last_vis;
    logic        r_buffer_sel,   n_buffer_sel;
    logic [15:0] r_error_count,  n_error_count;

    logic [15:0] pulse_len;
    logic [9:0]  window_first;
    logic        start_px;
    logic        fill_req;
    logic        fstart;
    logic        err;

    assign pulse_len    = i_capture_time - r_prev_capture;
    // The first field of a frame opens its window one line earlier.
    assign window_first = r_second ? vspc_pkg::WINDOW_START
                                   : vspc_pkg::WINDOW_START - 10'd1;

    // Next-state logic for one edge.
    always_comb begin
        n_prev_capture = i_capture_time;
        n_prev_length  = pulse_len;
        n_status       = r_status;
        n_second       = r_second;
        n_mode         = r_mode;
        n_broad_count  = r_broad_count;
        n_line         = r_line;
        n_line_total   = r_line_total;
        n_vis_index    = r_vis_index;
        n_next_vis     = r_next_vis;
        n_first_vis    = r_first_vis;
        n_last_vis     = r_last_vis;
        n_buffer_sel   = r_buffer_sel;
        start_px       = 1'b0;
        fill_req       = 1'b0;
        fstart         = 1'b0;
        err            = 1'b0;

        if (i_falling_edge) begin
            // Half-line gap after normal line: field type, else wait.
            if (pulse_len > i_cfg.vsync_min && pulse_len < i_cfg.vsync_max &&
                r_prev_length > i_cfg.hsync_min) begin
                case (r_mode)
                    vspc_pkg::STD_PAL:  n_second = 1'b1;
                    vspc_pkg::STD_NTSC: n_second = 1'b0;
                    default:            n_status = vspc_pkg::ST_WAIT;
                endcase
            end
        end else if (pulse_len < i_cfg.short_max) begin
            // Equalizing pulse.
            case (r_status)
                vspc_pkg::ST_WAIT, vspc_pkg::ST_HSYNC: begin
                    n_status = vspc_pkg::ST_PRE;
                end
                vspc_pkg::ST_PRE, vspc_pkg::ST_POST: begin
                end
                vspc_pkg::ST_SYNC: begin
                    n_status = vspc_pkg::ST_POST;
                    if (r_broad_count == vspc_pkg::PAL_BROAD) begin
                        n_mode      = vspc_pkg::STD_PAL;
                        n_first_vis = window_first;
                        n_last_vis  = window_first + PAL_SPAN;
                    end else if (r_broad_count == vspc_pkg::NTSC_BROAD) begin
                        n_mode      = vspc_pkg::STD_NTSC;
                        n_first_vis = window_first;
                        n_last_vis  = window_first + NTSC_SPAN;
                    end
                end
                default: begin
                    err = 1'b1;
                end
            endcase
        end else if (pulse_len < i_cfg.hsync_max) begin
            // Horizontal sync: start pixels for a line marked visible.
            if (r_next_vis) begin
                start_px    = 1'b1;
                n_vis_index = r_vis_index + 10'd1;
            end
            if (r_status == vspc_pkg::ST_POST || r_status == vspc_pkg::ST_HSYNC) begin
                n_status     = vspc_pkg::ST_HSYNC;
                n_line       = r_line + 10'd1;
                n_line_total = r_line_total + 16'd1;
                n_next_vis   = (n_line >= r_first_vis) && (n_line <= r_last_vis);
                if (n_next_vis) begin
                    n_buffer_sel = ~r_buffer_sel;
                    fill_req     = 1'b1;
                end
            end else begin
                err = 1'b1;
            end
        end else if (pulse_len >= i_cfg.broad_min && pulse_len <= i_cfg.broad_max) begin
            // Broad vertical sync pulse.
            case (r_status)
                vspc_pkg::ST_PRE: begin
                    n_status      = vspc_pkg::ST_SYNC;
                    n_broad_count = 8'd1;
                    if (r_second) begin
                        n_second = 1'b0;
                        fstart   = 1'b1;
                    end else begin
                        n_second = 1'b1;
                    end
                    n_line      = 10'd0;
                    n_vis_index = 10'd0;
                    n_next_vis  = 1'b0;
                end
                vspc_pkg::ST_POST: n_second      = 1'b1;
                vspc_pkg::ST_SYNC: n_broad_count = r_broad_count + 8'd1;
                default: ;
            endcase
        end else begin
            err = 1'b1;
        end

        n_error_count = r_error_count + {15'd0, err};
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_capture <= 16'd0;
            r_prev_length  <= 16'd0;
            r_status       <= vspc_pkg::ST_WAIT;
            r_second       <= 1'b0;
            r_mode         <= vspc_pkg::STD_UNKNOWN;
            r_broad_count  <= 8'd0;
            r_line         <= 10'd0;
            r_line_total   <= 16'd0;
            r_vis_index    <= 10'd0;
            r_next_vis     <= 1'b0;
            r_first_vis    <= 10'd0;
            r_last_vis     <= 10'd0;
            r_buffer_sel   <= 1'b0;
            r_error_count  <= 16'd0;
        end else if (i_en) begin
            r_prev_capture <= n_prev_capture;
            r_prev_length  <= n_prev_length;
            r_status       <= n_status;
            r_second       <= n_second;
            r_mode         <= n_mode;
            r_broad_count  <= n_broad_count;
            r_line         <= n_line;
            r_line_total   <= n_line_total;
            r_vis_index    <= n_vis_index;
            r_next_vis     <= n_next_vis;
            r_first_vis    <= n_first_vis;
            r_last_vis     <= n_last_vis;
            r_buffer_sel   <= n_buffer_sel;
            r_error_count  <= n_error_count;
        end
    end

    // Result fields reflect the state after this edge.
    always_comb begin
        o_result.sync_state   = n_status;
        o_result.second_field = n_second;
        o_result.video_mode   = n_mode;
        o_result.field_line   = n_line;
        o_result.frame_line   = n_line_total;
        o_result.visible_line = n_vis_index;
        o_result.start_pixels = start_px;
        o_result.fill_request = fill_req;
        o_result.fill_buffer  = n_buffer_sel;
        o_result.frame_start  = fstart;
        o_result.pulse_error  = err;
        o_result.error_total  = n_error_count;
    end

endmodule

FILE: rtl/video_sync_pulse_classifier_top.sv
// ============================================================================
// video_sync_pulse_classifier_top
// PAL/NTSC composite sync separator: classifies comparator edges and tracks
// field, line and visible window state.
// ============================================================================
// Each transaction on i_item is one comparator edge and produces exactly one
// result transaction on o_result. The block takes one edge per clock cycle
// unless o_result back-pressure holds it. An accepted edge waits in the input
// register; the classification logic behind it loads the result register
// as the edge leaves, and the result is offered from it. Back-pressure on
// o_result stalls the input side only once both registers are full.
// Thresholds are set over the APB port, one 16-bit register per word, and
// should be written while no edge is in flight.
module video_sync_pulse_classifier_top #(
    parameter int PAL_LINES_SHOWN  = 288,
    parameter int NTSC_LINES_SHOWN = 240
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    vspc_edge_if.sink             i_item,
    vspc_result_if.source         o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    vspc_pkg::t_cfg    cfg;
    vspc_pkg::t_result next_result;
    vspc_pkg::t_result r_result;

    logic        r_in_valid;
    logic [15:0] r_in_capture;
    logic        r_in_falling;
    logic        r_out_valid;
    logic        advance;
    logic        in_take;

    // Configuration registers.
    vspc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Pipeline control: the input register moves on whenever the result
    // register is free or being emptied.
    assign advance      = r_in_valid & (~r_out_valid | o_result.ready);
    assign i_item.ready = ~r_in_valid | advance;
    assign in_take      = i_item.valid & i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_capture <= i_item.capture_time;
            r_in_falling <= i_item.falling_edge;
        end
    end

    // Classification and state update.
    vspc_classifier #(
        .PAL_LINES_SHOWN  (PAL_LINES_SHOWN),
        .NTSC_LINES_SHOWN (NTSC_LINES_SHOWN)
    ) u_classifier (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (advance),
        .i_cfg          (cfg),
        .i_capture_time (r_in_capture),
        .i_falling_edge (r_in_falling),
        .o_result       (next_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= next_result;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.sync_state   = r_result.sync_state;
    assign o_result.second_field = r_result.second_field;
    assign o_result.video_mode   = r_result.video_mode;
    assign o_result.field_line   = r_result.field_line;
    assign o_result.frame_line   = r_result.frame_line;
    assign o_result.visible_line = r_result.visible_line;
    assign o_result.start_pixels = r_result.start_pixels;
    assign o_result.fill_request = r_result.fill_request;
    assign o_result.fill_buffer  = r_result.fill_buffer;
    assign o_result.frame_start  = r_result.frame_start;
    assign o_result.pulse_error  = r_result.pulse_error;
    assign o_result.error_total  = r_result.error_total;

endmodule

FILE: rtl/vspc_checker.sv
// ============================================================================
// vspc_checker
// Port-level checks on the sync pulse classifier, bound to the top level.
// ============================================================================
module vspc_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    vspc_result_if.source    o_result
);

    // A stalled result transaction stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && !o_result.ready |=> o_result.valid)
        else $error("result valid dropped while stalled");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result.valid)
        else $error("result valid after reset");

    // A buffer fill is only requested on a line in hsync state.
    a_fill_in_hsync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.fill_request |->
            o_result.sync_state == vspc_pkg::ST_HSYNC)
        else $error("fill request outside hsync lines");

    // A frame starts on the first broad pulse of the first field.
    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.frame_start |->
            o_result.sync_state == vspc_pkg::ST_SYNC && !o_result.second_field &&
            o_result.field_line == 10'd0 && o_result.visible_line == 10'd0)
        else $error("frame start with inconsistent field state");

endmodule

bind video_sync_pulse_classifier_top vspc_checker u_vspc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_result (o_result)
);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking testbench for the composite video sync pulse classifier.
// Comparator edges go in over a valid/ready channel and thresholds over APB.
// A cycle-free tracker in the bench predicts every result transaction, and
// a checker compares each one against the oldest prediction. The run covers
// directed corner cases, extreme threshold sets, full-length PAL and NTSC
// fields, and random video with noise, mostly under random back-pressure.
// ============================================================================
module tb_top;

    localparam int PAL_SHOWN    = 288;
    localparam int NTSC_SHOWN   = 240;
    localparam int CLK_HALF     = 5;
    localparam int RST_CYCLES   = 4;
    localparam int IDLE_LIMIT   = 3000;
    localparam int MAX_REPORTS  = 10;
    localparam int RANDOM_ITEMS = 40;
    localparam int NOISE_ITEMS  = 20;
    localparam int LONG_HOLD    = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    vspc_edge_if   comp_edges ();
    vspc_result_if sep_results ();

    video_sync_pulse_classifier_top #(
        .PAL_LINES_SHOWN  (PAL_SHOWN),
        .NTSC_LINES_SHOWN (NTSC_SHOWN)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (comp_edges),
        .o_result (sep_results),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock generation.
    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Sync tracker: the bench's own copy of thresholds and line state.
    // ------------------------------------------------------------------------
    vspc_pkg::t_cfg thr;
    logic [15:0] trk_prev_cap;
    logic [15:0] trk_prev_len;
    logic [2:0]  trk_state;
    logic        trk_second;
    logic [1:0]  trk_mode;
    logic [7:0]  trk_pre_cnt;
    logic [7:0]  trk_post_cnt;
    logic [7:0]  trk_broad_cnt;
    logic [9:0]  trk_line;
    logic [9:0]  trk_top_line;
    logic [15:0] trk_line_total;
    logic [9:0]  trk_vis_idx;
    logic        trk_next_vis;
    logic [9:0]  trk_win_first;
    logic [9:0]  trk_win_last;
    logic        trk_buf;
    logic [15:0] trk_frames;
    logic [15:0] trk_errors;
    logic [15:0] trk_falls;

    // Bookkeeping shared by the stimulus, the checker and the watchdog.
    vspc_pkg::t_result pending_results[$];
    int          edges_sent        = 0;
    int          results_checked   = 0;
    int          fail_count        = 0;
    int          report_count      = 0;
    int          frame_starts_seen = 0;
    int          pixel_starts_seen = 0;
    int          thr_sets_loaded   = 0;
    int          idle_cycles       = 0;
    int          rx_hold_left      = 0;
    bit          rx_stall_on       = 1'b0;
    bit          tx_gaps_on        = 1'b0;
    int          burst_left        = 0;
    logic [15:0] tx_time;

    function automatic vspc_pkg::t_cfg default_thresholds();
        vspc_pkg::t_cfg c;
        c.vsync_min = 16'd1280;
        c.vsync_max = 16'd2292;
        c.hsync_min = 16'd320;
        c.short_max = 16'd280;
        c.hsync_max = 16'd480;
        c.broad_min = 16'd2000;
        c.broad_max = 16'd2320;
        return c;
    endfunction

    task automatic reset_tracker();
        thr            = default_thresholds();
        trk_prev_cap   = '0;
        trk_prev_len   = '0;
        trk_state      = vspc_pkg::ST_WAIT;
        trk_second     = 1'b0;
        trk_mode       = vspc_pkg::STD_UNKNOWN;
        trk_pre_cnt    = '0;
        trk_post_cnt   = '0;
        trk_broad_cnt  = '0;
        trk_line       = '0;
        trk_top_line   = '0;
        trk_line_total = '0;
        trk_vis_idx    = '0;
        trk_next_vis   = 1'b0;
        trk_win_first  = '0;
        trk_win_last   = '0;
        trk_buf        = 1'b0;
        trk_frames     = '0;
        trk_errors     = '0;
        trk_falls      = '0;
    endtask

    // The first field opens its visible window one line earlier.
    function automatic void open_window(input int shown);
        logic [9:0] first;
        logic [9:0] span;
        first = vspc_pkg::WINDOW_START;
        if (!trk_second) begin
            first = first - 10'd1;
        end
        span          = 10'(shown - 1);
        trk_win_first = first;
        trk_win_last  = span + first;
    endfunction

    // Advances the tracker by one comparator edge and returns its result.
    function automatic vspc_pkg::t_result classify_edge(input logic [15:0] cap,
                                                        input logic fall);
        logic [15:0] len;
        logic        err;
        logic        px;
        logic        fill;
        logic        fstart;
        vspc_pkg::t_result r;
        len    = cap - trk_prev_cap;
        err    = 1'b0;
        px     = 1'b0;
        fill   = 1'b0;
        fstart = 1'b0;
        if (fall) begin
            // A half-line gap after a normal line tells the field type, else back to waiting.
            if (len > thr.vsync_min && len < thr.vsync_max && trk_prev_len > thr.hsync_min) begin
                if (trk_mode == vspc_pkg::STD_PAL) begin
                    trk_second = 1'b1;
                end else if (trk_mode == vspc_pkg::STD_NTSC) begin
                    trk_second = 1'b0;
                end else begin
                    trk_state = vspc_pkg::ST_WAIT;
                end
            end
            trk_falls = trk_falls + 16'd1;
        end else if (len < thr.short_max) begin
            // Equalizing pulse.
            case (trk_state)
                vspc_pkg::ST_WAIT, vspc_pkg::ST_HSYNC: begin
                    trk_state   = vspc_pkg::ST_PRE;
                    trk_pre_cnt = 8'd1;
                end
                vspc_pkg::ST_PRE: begin
                    trk_pre_cnt = trk_pre_cnt + 8'd1;
                end
                vspc_pkg::ST_POST: begin
                    trk_post_cnt = trk_post_cnt + 8'd1;
                end
                vspc_pkg::ST_SYNC: begin
                    trk_state    = vspc_pkg::ST_POST;
                    trk_post_cnt = 8'd1;
                    if (trk_broad_cnt == vspc_pkg::PAL_BROAD) begin
                        trk_mode = vspc_pkg::STD_PAL;
                        open_window(PAL_SHOWN);
                    end else if (trk_broad_cnt == vspc_pkg::NTSC_BROAD) begin
                        trk_mode = vspc_pkg::STD_NTSC;
                        open_window(NTSC_SHOWN);
                    end
                end
                default: begin
                    err = 1'b1;
                end
            endcase
        end else if (len < thr.hsync_max) begin
            // Horizontal sync: pixels start if the line was marked visible.
            if (trk_next_vis) begin
                px          = 1'b1;
                trk_vis_idx = trk_vis_idx + 10'd1;
            end
            if (trk_state == vspc_pkg::ST_POST || trk_state == vspc_pkg::ST_HSYNC) begin
                trk_state      = vspc_pkg::ST_HSYNC;
                trk_line       = trk_line + 10'd1;
                trk_line_total = trk_line_total + 16'd1;
                trk_next_vis   = (trk_line >= trk_win_first) && (trk_line <= trk_win_last);
                if (trk_next_vis) begin
                    trk_buf = ~trk_buf;
                    fill    = 1'b1;
                end
                if (trk_line > trk_top_line) begin
                    trk_top_line = trk_line;
                end
            end else begin
                err = 1'b1;
            end
        end else if (len >= thr.broad_min && len <= thr.broad_max) begin
            // Broad pulse: only counts after pre-equalizing has begun.
            if (trk_state == vspc_pkg::ST_PRE) begin
                trk_state     = vspc_pkg::ST_SYNC;
                trk_broad_cnt = '0;
                if (trk_second) begin
                    trk_second = 1'b0;
                    trk_frames = trk_frames + 16'd1;
                    fstart     = 1'b1;
                end else begin
                    trk_second = 1'b1;
                end
                trk_line     = '0;
                trk_vis_idx  = '0;
                trk_next_vis = 1'b0;
            end
            if (trk_state == vspc_pkg::ST_POST) begin
                trk_second = 1'b1;
            end
            if (trk_state == vspc_pkg::ST_SYNC) begin
                trk_broad_cnt = trk_broad_cnt + 8'd1;
            end
        end else begin
            err = 1'b1;
        end

        if (err) begin
            trk_errors = trk_errors + 16'd1;
        end
        trk_prev_len = len;
        trk_prev_cap = cap;

        r.sync_state   = trk_state;
        r.second_field = trk_second;
        r.video_mode   = trk_mode;
        r.field_line   = trk_line;
        r.frame_line   = trk_line_total;
        r.visible_line = trk_vis_idx;
        r.start_pixels = px;
        r.fill_request = fill;
        r.fill_buffer  = trk_buf;
        r.frame_start  = fstart;
        r.pulse_error  = err;
        r.error_total  = trk_errors;
        return r;
    endfunction

    function automatic string show_result(input vspc_pkg::t_result r);
        return $sformatf({"state=%0d second=%0d mode=%0d fline=%0d frline=%0d vline=%0d ",
                          "start=%0b fill=%0b buf=%0b fstart=%0b err=%0b errs=%0d"},
                         r.sync_state, r.second_field, r.video_mode, r.field_line,
                         r.frame_line, r.visible_line, r.start_pixels, r.fill_request,
                         r.fill_buffer, r.frame_start, r.pulse_error, r.error_total);
    endfunction

    // ------------------------------------------------------------------------
    // Edge sender: with gaps on, bursts of random length separated by random gaps.
    // ------------------------------------------------------------------------
    task automatic send_edge(input logic [15:0] cap, input logic fall);
        int gap;
        if (tx_gaps_on && burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = $urandom_range(1, 10);
            @(negedge i_clk);
            comp_edges.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        burst_left = burst_left - 1;
        @(negedge i_clk);
        comp_edges.valid        <= 1'b1;
        comp_edges.capture_time <= cap;
        comp_edges.falling_edge <= fall;
        @(posedge i_clk);
        while (!comp_edges.ready) begin
            @(posedge i_clk);
        end
        pending_results.push_back(classify_edge(cap, fall));
        edges_sent++;
    endtask

    // Stops offering edges and waits until every result has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        comp_edges.valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
    endtask

    // One low pulse: falling edge now, rising edge after the low time.
    task automatic send_pulse(input logic [15:0] low, input logic [15:0] high);
        send_edge(tx_time, 1'b1);
        tx_time = tx_time + low;
        send_edge(tx_time, 1'b0);
        tx_time = tx_time + high;
    endtask

    function automatic logic [15:0] eq_width();
        return 16'($urandom_range(0, thr.short_max - 1));
    endfunction

    function automatic logic [15:0] hsync_width();
        return 16'($urandom_range(thr.hsync_min + 1, thr.hsync_max - 1));
    endfunction

    // ------------------------------------------------------------------------
    // APB threshold access: write, then read back and compare.
    // ------------------------------------------------------------------------
    task automatic write_threshold(input logic [vspc_pkg::REG_IDX_W-1:0] idx,
                                   input logic [15:0] value);
        logic [31:0] rd;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        case (idx)
            vspc_pkg::REG_VSYNC_MIN: thr.vsync_min = value;
            vspc_pkg::REG_VSYNC_MAX: thr.vsync_max = value;
            vspc_pkg::REG_HSYNC_MIN: thr.hsync_min = value;
            vspc_pkg::REG_SHORT_MAX: thr.short_max = value;
            vspc_pkg::REG_HSYNC_MAX: thr.hsync_max = value;
            vspc_pkg::REG_BROAD_MIN: thr.broad_min = value;
            vspc_pkg::REG_BROAD_MAX: thr.broad_max = value;
            default: ;
        endcase
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== {16'h0000, value}) begin
            fail_count++;
            if (report_count < MAX_REPORTS) begin
                report_count++;
                $display("ERROR: register %0d read back %h, expected %h", idx, rd, value);
            end
        end
    endtask

    task automatic load_thresholds(input vspc_pkg::t_cfg c);
        write_threshold(vspc_pkg::REG_VSYNC_MIN, c.vsync_min);
        write_threshold(vspc_pkg::REG_VSYNC_MAX, c.vsync_max);
        write_threshold(vspc_pkg::REG_HSYNC_MIN, c.hsync_min);
        write_threshold(vspc_pkg::REG_SHORT_MAX, c.short_max);
        write_threshold(vspc_pkg::REG_HSYNC_MAX, c.hsync_max);
        write_threshold(vspc_pkg::REG_BROAD_MIN, c.broad_min);
        write_threshold(vspc_pkg::REG_BROAD_MAX, c.broad_max);
        thr_sets_loaded++;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus generators.
    // ------------------------------------------------------------------------

    // Random edges, with many lengths placed right at the thresholds.
    task automatic send_noise(input int count);
        int          k;
        logic [15:0] span;
        logic [15:0] base;
        logic [15:0] jig;
        for (k = 0; k < count; k++) begin
            case ($urandom_range(3))
                0: begin
                    span = 16'($urandom_range(0, 65535));
                end
                1: begin
                    case ($urandom_range(6))
                        0: base = thr.vsync_min;
                        1: base = thr.vsync_max;
                        2: base = thr.hsync_min;
                        3: base = thr.short_max;
                        4: base = thr.hsync_max;
                        5: base = thr.broad_min;
                        default: base = thr.broad_max;
                    endcase
                    jig  = 16'($urandom_range(2));
                    span = base + jig - 16'd1;
                end
                default: begin
                    span = 16'($urandom_range(0, 4500));
                end
            endcase
            tx_time = tx_time + span;
            send_edge(tx_time, 1'($urandom_range(1)));
        end
    endtask

    // One vertical interval followed by a run of lines. A stray hsync among
    // the pre-equalizing pulses makes a broken sequence.
    task automatic send_field(input int eq_pulses, input int broad_pulses, input int lines,
                              input bit stray_hsync);
        int          i;
        logic [15:0] low;
        logic [15:0] high;
        for (i = 0; i < eq_pulses; i++) begin
            send_pulse(eq_width(), 16'($urandom_range(1500, 2100)));
            if (stray_hsync && i == 0) begin
                send_pulse(hsync_width(), 16'($urandom_range(1500, 2100)));
            end
        end
        for (i = 0; i < broad_pulses; i++) begin
            case ($urandom_range(3))
                0: low = thr.broad_min;
                1: low = thr.broad_max;
                default: low = 16'($urandom_range(thr.broad_min, thr.broad_max));
            endcase
            send_pulse(low, 16'($urandom_range(100, 300)));
        end
        for (i = 0; i < eq_pulses; i++) begin
            send_pulse(eq_width(), 16'($urandom_range(1500, 2100)));
        end
        for (i = 0; i < lines; i++) begin
            // The last line may end on a half-line gap.
            if (i == lines - 1 && $urandom_range(1)) begin
                high = 16'($urandom_range(thr.vsync_min + 1, thr.vsync_max - 1));
            end else begin
                high = 16'($urandom_range(3000, 3800));
            end
            send_pulse(hsync_width(), high);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Corner cases from reset, no idling on either side.
    task automatic test_directed();
        tx_gaps_on  = 1'b0;
        rx_stall_on = 1'b0;
        // Zero-length pulse from waiting starts pre-equalizing.
        send_edge(16'h0000, 1'b0);
        // Longest possible pulse is an error.
        send_edge(16'hFFFF, 1'b0);
        send_edge(16'h0000, 1'b1);
        // Hsync during pre-equalizing is an error.
        send_edge(16'd400, 1'b0);
        // Half-line gap with the standard still unknown falls back to waiting.
        send_edge(16'd2200, 1'b1);
        // Broad pulse while waiting is ignored.
        send_edge(16'd4300, 1'b0);
        tx_time = 16'd4500;
        // Short vertical interval with five broad pulses selects PAL.
        send_pulse(16'd150, 16'd1900);
        repeat (vspc_pkg::PAL_BROAD) send_pulse(16'd2100, 16'd200);
        send_pulse(16'd150, 16'd1900);
        // A line ending in a half-line gap marks the second field.
        send_pulse(16'd400, 16'd1800);
        send_edge(tx_time, 1'b1);
        wait_drained();
    endtask

    // Zero, all-ones, random and reset thresholds, each with random edges.
    task automatic test_threshold_extremes();
        int             k;
        vspc_pkg::t_cfg setting;
        tx_gaps_on  = 1'b1;
        rx_stall_on = 1'b1;
        for (k = 0; k < 4; k++) begin
            case (k)
                0: setting = '0;
                1: setting = '1;
                2: begin
                    setting.vsync_min = 16'($urandom_range(0, 65535));
                    setting.vsync_max = 16'($urandom_range(0, 65535));
                    setting.hsync_min = 16'($urandom_range(0, 65535));
                    setting.short_max = 16'($urandom_range(0, 65535));
                    setting.hsync_max = 16'($urandom_range(0, 65535));
                    setting.broad_min = 16'($urandom_range(0, 65535));
                    setting.broad_max = 16'($urandom_range(0, 65535));
                end
                default: setting = default_thresholds();
            endcase
            load_thresholds(setting);
            send_noise(NOISE_ITEMS);
            wait_drained();
        end
    endtask

    // Full PAL and NTSC fields that run past the end of the visible window.
    task automatic test_long_fields();
        tx_gaps_on   = 1'b1;
        rx_stall_on  = 1'b1;
        // The receiver holds off for a long stretch while edges keep coming.
        rx_hold_left = LONG_HOLD;
        send_field(vspc_pkg::PAL_BROAD, vspc_pkg::PAL_BROAD, PAL_SHOWN + 18, 1'b0);
        wait_drained();
        tx_gaps_on  = 1'b0;
        rx_stall_on = 1'b0;
        send_field(vspc_pkg::NTSC_BROAD, vspc_pkg::NTSC_BROAD, NTSC_SHOWN + 18, 1'b0);
        wait_drained();
    endtask

    // Mostly well-formed fields with random content, some broken, some noise.
    task automatic test_random_video();
        int             start;
        int             pick;
        int             broads;
        bit             switched;
        vspc_pkg::t_cfg alt;
        tx_gaps_on  = 1'b1;
        rx_stall_on = 1'b1;
        start       = edges_sent;
        switched    = 1'b0;
        while (edges_sent - start < RANDOM_ITEMS) begin
            // Halfway through, move to a second realistic threshold set.
            if (!switched && edges_sent - start >= RANDOM_ITEMS / 2) begin
                wait_drained();
                alt.vsync_min = 16'd1300;
                alt.vsync_max = 16'd2250;
                alt.hsync_min = 16'd330;
                alt.short_max = 16'd290;
                alt.hsync_max = 16'd470;
                alt.broad_min = 16'd1990;
                alt.broad_max = 16'd2330;
                load_thresholds(alt);
                switched = 1'b1;
            end
            if ($urandom_range(9) == 0) begin
                wait_drained();
            end
            pick = $urandom_range(99);
            if (pick < 70) begin
                broads = $urandom_range(1) ? vspc_pkg::PAL_BROAD : vspc_pkg::NTSC_BROAD;
                send_field(broads, broads, $urandom_range(2, 30), 1'b0);
            end else if (pick < 82) begin
                send_field($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 30),
                           1'($urandom_range(1)));
            end else begin
                send_noise($urandom_range(3, 15));
            end
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Result receiver: random short stalls when enabled, plus an optional long hold-off.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall_left;
        stall_left        = 0;
        sep_results.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                sep_results.ready <= 1'b0;
                rx_hold_left = rx_hold_left - 1;
            end else if (stall_left > 0) begin
                sep_results.ready <= 1'b0;
                stall_left = stall_left - 1;
            end else begin
                sep_results.ready <= 1'b1;
                if (rx_stall_on && $urandom_range(99) < 20) begin
                    stall_left = $urandom_range(1, 8);
                end
            end
        end
    end

    // Compare each result transaction with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        vspc_pkg::t_result got;
        vspc_pkg::t_result want;
        if (i_rst_n && sep_results.valid && sep_results.ready) begin
            got.sync_state   = sep_results.sync_state;
            got.second_field = sep_results.second_field;
            got.video_mode   = sep_results.video_mode;
            got.field_line   = sep_results.field_line;
            got.frame_line   = sep_results.frame_line;
            got.visible_line = sep_results.visible_line;
            got.start_pixels = sep_results.start_pixels;
            got.fill_request = sep_results.fill_request;
            got.fill_buffer  = sep_results.fill_buffer;
            got.frame_start  = sep_results.frame_start;
            got.pulse_error  = sep_results.pulse_error;
            got.error_total  = sep_results.error_total;
            results_checked++;
            if (got.start_pixels === 1'b1) begin
                pixel_starts_seen++;
            end
            if (got.frame_start === 1'b1) begin
                frame_starts_seen++;
            end
            if (pending_results.size() == 0) begin
                fail_count++;
                if (report_count < MAX_REPORTS) begin
                    report_count++;
                    $display("ERROR: result with none expected: %s", show_result(got));
                end
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (report_count < MAX_REPORTS) begin
                        report_count++;
                        $display("ERROR: result %0d mismatch", results_checked);
                        $display("  expected %s", show_result(want));
                        $display("  actual   %s", show_result(got));
                    end
                end
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge i_clk) begin
        if ((comp_edges.valid && comp_edges.ready) || (sep_results.valid && sep_results.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("ERROR: no transaction for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, pending_results.size());
            $display("simulation failed");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        i_clk                   = 1'b0;
        i_rst_n                 = 1'b0;
        comp_edges.valid        = 1'b0;
        comp_edges.capture_time = '0;
        comp_edges.falling_edge = 1'b0;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = '0;
        pwdata                  = '0;
        tx_time                 = '0;
        reset_tracker();
        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_threshold_extremes();
        test_long_fields();
        test_random_video();

        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("Checked %0d results from %0d comparator edges: %0d frame starts, %0d pixel lines.",
                 results_checked, edges_sent, frame_starts_seen, pixel_starts_seen);
        $display("Covered %0d threshold sets, PAL and NTSC fields, noise and a long output stall.",
                 thr_sets_loaded);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/vspc_pkg.sv
rtl/vspc_if.sv
rtl/vspc_apb_regs.sv
rtl/vspc_classifier.sv
rtl/video_sync_pulse_classifier_top.sv
rtl/vspc_checker.sv
tb/tb_top.sv
